@@ hw/rtl/tgli_pkg.sv @@
// Shared constants for the triangle grid interpolator.
// No dependencies; used by the core and the node store.
package tgli_pkg;

  localparam int MAX_CELLS_X_DEF = 64;
  localparam int MAX_CELLS_Y_DEF = 64;
  localparam int NODE_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int ONE_Q16         = 65536;
  localparam int ROUND_HALF      = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y    = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [30:0] INV_STEP_RESET = 31'd65536;
  localparam logic [6:0]  CELLS_RESET    = 7'd64;

endpackage

@@ hw/rtl/tgli_node_store.sv @@
// Node value store: three identical copies so that one query reads
// three nodes in a cycle. Depends on tgli_pkg.
module tgli_node_store #(
  parameter int DEPTH = 4225,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [tgli_pkg::NODE_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr_a,
  input  logic [AW-1:0]                 rd_addr_b,
  input  logic [AW-1:0]                 rd_addr_c,
  output logic [tgli_pkg::NODE_W-1:0]   rd_data_a,
  output logic [tgli_pkg::NODE_W-1:0]   rd_data_b,
  output logic [tgli_pkg::NODE_W-1:0]   rd_data_c
);

  logic [tgli_pkg::NODE_W-1:0] mem_a [DEPTH];
  logic [tgli_pkg::NODE_W-1:0] mem_b [DEPTH];
  logic [tgli_pkg::NODE_W-1:0] mem_c [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
      mem_c[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem_a[rd_addr_a];
      rd_data_b <= mem_b[rd_addr_b];
      rd_data_c <= mem_c[rd_addr_c];
    end
  end

endmodule

@@ hw/rtl/triangle_grid_linear_interpolator_core.sv @@
// Triangle grid linear interpolator, nine stage pipeline.
// Depends on tgli_pkg and tgli_node_store.
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  operation node_index node_value x_coord y_coord
//  out      source     out_valid/out_stall value triangle_index
//  cfg      sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// One request enters per cycle while in_stall is low; query results leave in order from the last stage.
// Throughput is set by the replicated node store, read at three ports at once.
// Writes update the store in stage five and leave the pipe there.
// rst is synchronous; it clears valid bits and sets configuration to its reset values; the store is not cleared.
// A stalled output holds each stage that is full; empty stages still fill.
module triangle_grid_linear_interpolator_core #(
  parameter int MAX_CELLS_X = tgli_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = tgli_pkg::MAX_CELLS_Y_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [12:0]                     node_index,
  input  logic signed [31:0]              node_value,
  input  logic signed [31:0]              x_coord,
  input  logic signed [31:0]              y_coord,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              value,
  output logic [12:0]                     triangle_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int DEPTH = (MAX_CELLS_X + 1) * (MAX_CELLS_Y + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_CELLS_X + 1);
  localparam int YW    = $clog2(MAX_CELLS_Y + 1);
  localparam int TW    = (AW > 12) ? AW : 12;

  // configuration
  logic signed [31:0] origin_x, origin_y;
  logic [30:0]        inv_step_x, inv_step_y;
  logic [6:0]         cells_x, cells_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      inv_step_x <= tgli_pkg::INV_STEP_RESET;
      inv_step_y <= tgli_pkg::INV_STEP_RESET;
      cells_x    <= tgli_pkg::CELLS_RESET;
      cells_y    <= tgli_pkg::CELLS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgli_pkg::CFG_ORIGIN_X:   origin_x   <= cfg_data;
        tgli_pkg::CFG_ORIGIN_Y:   origin_y   <= cfg_data;
        tgli_pkg::CFG_INV_STEP_X: inv_step_x <= cfg_data[30:0];
        tgli_pkg::CFG_INV_STEP_Y: inv_step_y <= cfg_data[30:0];
        tgli_pkg::CFG_CELLS_X:    cells_x    <= cfg_data[6:0];
        tgli_pkg::CFG_CELLS_Y:    cells_y    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0] nx;
  logic [YW-1:0] ny;

  always_comb begin
    if (cells_x == '0)                   nx = XW'(1);
    else if (int'(cells_x) > MAX_CELLS_X) nx = XW'(MAX_CELLS_X);
    else                                 nx = XW'(cells_x);
    if (cells_y == '0)                   ny = YW'(1);
    else if (int'(cells_y) > MAX_CELLS_Y) ny = YW'(MAX_CELLS_Y);
    else                                 ny = YW'(cells_y);
  end

  // pipeline control
  logic [9:1] vld;
  logic [9:1] ld;
  logic       op4;

  always_comb begin
    ld[9] = !vld[9] || !out_stall;
    for (int k = 8; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = vld[9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) vld[1] <= in_valid;
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
      if (ld[5]) vld[5] <= vld[4] && (op4 == tgli_pkg::OP_QUERY);
      if (ld[6]) vld[6] <= vld[5];
      if (ld[7]) vld[7] <= vld[6];
      if (ld[8]) vld[8] <= vld[7];
      if (ld[9]) vld[9] <= vld[8];
    end
  end

  // stage 1: offsets from origin
  logic               op1, op2, op3;
  logic [12:0]        idx1, idx2, idx3, idx4;
  logic [31:0]        val1, val2, val3, val4;
  logic signed [32:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op1  <= operation;
      idx1 <= node_index;
      val1 <= node_value;
      dx1  <= 33'(x_coord) - 33'(origin_x);
      dy1  <= 33'(y_coord) - 33'(origin_y);
    end
  end

  // stage 2: scale to cell coordinates
  logic signed [64:0] tx, ty;
  logic signed [47:0] cx2, cy2;

  assign tx = dx1 * $signed({1'b0, inv_step_x});
  assign ty = dy1 * $signed({1'b0, inv_step_y});

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      op2  <= op1;
      idx2 <= idx1;
      val2 <= val1;
      cx2  <= tx[63:16];
      cy2  <= ty[63:16];
    end
  end

  // stage 3: clamp cell index, fractional parts
  logic signed [31:0] fi, fj, nxm1_s, nym1_s;
  logic [XW-1:0]      ic;
  logic [YW-1:0]      jc;
  logic [XW-1:0]      i3;
  logic [YW-1:0]      j3;
  logic signed [48:0] u3, v3;

  assign fi     = cx2[47:16];
  assign fj     = cy2[47:16];
  assign nxm1_s = $signed(32'(nx - XW'(1)));
  assign nym1_s = $signed(32'(ny - YW'(1)));

  always_comb begin
    if (fi < 0)           ic = '0;
    else if (fi > nxm1_s) ic = nx - XW'(1);
    else                  ic = fi[XW-1:0];
    if (fj < 0)           jc = '0;
    else if (fj > nym1_s) jc = ny - YW'(1);
    else                  jc = fj[YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      op3  <= op2;
      idx3 <= idx2;
      val3 <= val2;
      i3   <= ic;
      j3   <= jc;
      u3   <= 49'(cx2) - $signed(49'({ic, 16'h0000}));
      v3   <= 49'(cy2) - $signed(49'({jc, 16'h0000}));
    end
  end

  // stage 4: triangle choice, weights, node addresses
  logic signed [49:0] uv_sum;
  logic               upper;
  logic [AW-1:0]      base, row;
  logic [TW-1:0]      tri_lin;
  logic signed [50:0] w0c, w1c, w2c;
  logic signed [50:0] w0_4, w1_4, w2_4;
  logic [AW-1:0]      a4, b4, c4;
  logic [12:0]        tri4;

  assign uv_sum  = 50'(u3) + 50'(v3);
  assign upper   = !(u3 >= 0 && v3 >= 0 && uv_sum <= 50'(tgli_pkg::ONE_Q16));
  assign row     = AW'(ny) + AW'(1);
  assign base    = AW'(i3) * row + AW'(j3);
  assign tri_lin = TW'(base) - TW'(i3);

  always_comb begin
    if (!upper) begin
      w0c = 51'(tgli_pkg::ONE_Q16) - 51'(u3) - 51'(v3);
      w1c = 51'(u3);
      w2c = 51'(v3);
    end else begin
      w0c = 51'(tgli_pkg::ONE_Q16) - 51'(v3);
      w1c = 51'(u3) + 51'(v3) - 51'(tgli_pkg::ONE_Q16);
      w2c = 51'(tgli_pkg::ONE_Q16) - 51'(u3);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      op4  <= op3;
      idx4 <= idx3;
      val4 <= val3;
      w0_4 <= w0c;
      w1_4 <= w1c;
      w2_4 <= w2c;
      a4   <= upper ? base + row : base;
      b4   <= upper ? base + row + AW'(1) : base + row;
      c4   <= base + AW'(1);
      tri4 <= {tri_lin[11:0], upper};
    end
  end

  // stage 5: node store access
  logic [31:0]        n0_5, n1_5, n2_5;
  logic signed [50:0] w0_5, w1_5, w2_5;
  logic [12:0]        tri5;
  logic               wr_en, rd_en;

  assign wr_en = ld[5] && vld[4] && (op4 == tgli_pkg::OP_WRITE) && (int'(idx4) < DEPTH);
  assign rd_en = ld[5] && vld[4] && (op4 == tgli_pkg::OP_QUERY);

  tgli_node_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(idx4)),
    .wr_data   (val4),
    .rd_en     (rd_en),
    .rd_addr_a (a4),
    .rd_addr_b (b4),
    .rd_addr_c (c4),
    .rd_data_a (n0_5),
    .rd_data_b (n1_5),
    .rd_data_c (n2_5)
  );

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      w0_5 <= w0_4;
      w1_5 <= w1_4;
      w2_5 <= w2_4;
      tri5 <= tri4;
    end
  end

  // stage 6: partial products, weight split at bit 26
  logic signed [58:0] plo0, plo1, plo2;
  logic signed [56:0] phi0, phi1, phi2;
  logic [12:0]        tri6;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      plo0 <= $signed(n0_5) * $signed({1'b0, w0_5[25:0]});
      plo1 <= $signed(n1_5) * $signed({1'b0, w1_5[25:0]});
      plo2 <= $signed(n2_5) * $signed({1'b0, w2_5[25:0]});
      phi0 <= $signed(n0_5) * $signed(w0_5[50:26]);
      phi1 <= $signed(n1_5) * $signed(w1_5[50:26]);
      phi2 <= $signed(n2_5) * $signed(w2_5[50:26]);
      tri6 <= tri5;
    end
  end

  // stage 7: column sums
  logic signed [60:0] slo;
  logic signed [58:0] shi;
  logic [12:0]        tri7;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      slo  <= 61'(plo0) + 61'(plo1) + 61'(plo2);
      shi  <= 59'(phi0) + 59'(phi1) + 59'(phi2);
      tri7 <= tri6;
    end
  end

  // stage 8: combine and round
  logic signed [84:0] acc;
  logic [12:0]        tri8;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      acc  <= $signed({shi, 26'h0}) + 85'(slo) + 85'(tgli_pkg::ROUND_HALF);
      tri8 <= tri7;
    end
  end

  // stage 9: saturate
  logic [68:0] rq;
  logic [31:0] sat;

  assign rq = acc[84:16];

  always_comb begin
    if ((&rq[68:31]) || !(|rq[68:31])) sat = rq[31:0];
    else if (rq[68])                   sat = 32'h8000_0000;
    else                               sat = 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      value          <= sat;
      triangle_index <= tri8;
    end
  end

endmodule

@@ hw/rtl/tgli_checker.sv @@
// Port level checks for the triangle grid interpolator core.
// No package dependencies; bound to triangle_grid_linear_interpolator_core.
module tgli_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [31:0]             value,
  input logic [12:0]                    triangle_index,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(triangle_index))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without output back pressure");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind triangle_grid_linear_interpolator_core tgli_checker u_tgli_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .value          (value),
  .triangle_index (triangle_index),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
